FILE: src/oaht_pkg.sv
`default_nettype none
package oaht_pkg;

  localparam int TableSizeDef = 256;
  localparam int HomePrimeDef = 251;
  localparam int KeyBitsDef   = 32;
  localparam int ValueBitsDef = 32;

  localparam int CmdW   = 2;
  localparam int FieldW = 32;
  localparam int LiveW  = 9;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // slot kinds seen by the controller
  typedef enum logic [1:0] {
    SK_EMPTY = 2'd0,
    SK_TOMB  = 2'd1,
    SK_MATCH = 2'd2,
    SK_OTHER = 2'd3
  } slot_kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch a new command and form the home hash
    logic home;      // one step of the home index reduction
    logic rd;        // issue a read of the current probe index
    logic step;      // advance the triangular probe
    logic note_tomb; // remember current index as first tombstone
    logic wr_new;    // write tag/key/value into the chosen free slot
    logic wr_upd;    // write new value at the hit slot
    logic wr_rm;     // write a tombstone at the hit slot
    logic clr;       // clear one slot tag, advance sweep index
    logic cnt_clr;   // zero both counts
    logic hit;       // record a hit, capture old value
    logic full;      // record table full
    logic emit;      // load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t       cmd;
    slot_kind_t kind;
    logic       has_tomb;
    logic       home_done;
    logic       probe_last;
    logic       sweep_last;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: src/oaht_if.sv
`default_nettype none
interface oaht_in_if import oaht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [FieldW-1:0] key;
  logic [FieldW-1:0] value;
  modport source(output valid, command, key, value, input ready);
  modport sink(input valid, command, key, value, output ready);
endinterface

interface oaht_out_if import oaht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [FieldW-1:0] old_value;
  logic              status;
  logic [LiveW-1:0]  live_entries;
  modport source(output valid, found, old_value, status, live_entries, input ready);
  modport sink(input valid, found, old_value, status, live_entries, output ready);
endinterface
`default_nettype wire

FILE: src/oaht_ctrl.sv
`default_nettype none
module oaht_ctrl import oaht_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     res_busy,
  input  wire logic     res_take,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HOME  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_INIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // accept only when idle
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        // clearing pass over every slot tag after reset
        cmd.clr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        if (stat.cmd == CMD_CLEAR) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_CLEAR;
        end else if (stat.home_done) begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          cmd.home = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (stat.kind)
          SK_EMPTY: begin
            if (stat.cmd == CMD_INSERT) begin
              cmd.wr_new = 1'b1;
            end
            state_nxt = S_DONE;
          end
          SK_MATCH: begin
            cmd.hit = 1'b1;
            if (stat.cmd == CMD_INSERT) begin
              cmd.wr_upd = 1'b1;
            end else if (stat.cmd == CMD_REMOVE) begin
              cmd.wr_rm = 1'b1;
            end
            state_nxt = S_DONE;
          end
          default: begin
            if (stat.kind == SK_TOMB && !stat.has_tomb) begin
              cmd.note_tomb = 1'b1;
            end
            if (stat.probe_last) begin
              // probe bound reached without an empty slot
              if (stat.cmd == CMD_INSERT) begin
                if (stat.has_tomb || stat.kind == SK_TOMB) begin
                  cmd.wr_new = 1'b1;
                end else begin
                  cmd.full = 1'b1;
                end
              end
              state_nxt = S_DONE;
            end else begin
              cmd.step  = 1'b1;
              state_nxt = S_READ;
            end
          end
        endcase
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait here while the previous result beat is still held
        if (!res_busy || res_take) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one command strobe a cycle at most for writes
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.wr_new, cmd.wr_upd, cmd.wr_rm, cmd.clr}) <= 1)
    else $error("more than one table write");
  a_emit_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> state_r == S_DONE)
    else $error("result emitted without finishing a command");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_HOME)
    else $error("load did not start a command");

endmodule
`default_nettype wire

FILE: src/oaht_dp.sv
`default_nettype none
module oaht_dp import oaht_pkg::*; #(
  parameter int TABLE_SIZE = TableSizeDef,
  parameter int HOME_PRIME = HomePrimeDef,
  parameter int KEY_BITS   = KeyBitsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CmdW-1:0]   in_command,
  input  wire logic [FieldW-1:0] in_key,
  input  wire logic [FieldW-1:0] in_value,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output logic                   res_busy,
  input  wire logic              res_take,
  output logic                   res_found,
  output logic [FieldW-1:0]      res_old_value,
  output logic                   res_status,
  output logic [LiveW-1:0]       res_live
);

  // key and value widths as carried by the beat fields
  localparam int KB   = (KEY_BITS < FieldW) ? KEY_BITS : FieldW;
  localparam int VB   = (VALUE_BITS < FieldW) ? VALUE_BITS : FieldW;
  localparam int IdxW = $clog2(TABLE_SIZE);
  localparam int CntW = IdxW + 1;
  localparam int PW   = $clog2(HOME_PRIME + 1);
  // reciprocal of the prime: (x * RecipM) >> RecipSh is x / HOME_PRIME for any KB-bit x
  localparam int RecipSh = KB + $clog2(HOME_PRIME);
  localparam logic [KB:0] RecipM =
    (KB+1)'(((64'd1 << RecipSh) + 64'(HOME_PRIME) - 64'd1) / 64'(HOME_PRIME));
  localparam logic [PW-1:0] PrimeP = PW'(HOME_PRIME);
  // home reduction steps
  localparam logic [1:0] HsMul  = 2'd0;
  localparam logic [1:0] HsQp   = 2'd1;
  localparam logic [1:0] HsSub  = 2'd2;
  localparam logic [1:0] HsDone = 2'd3;

  // slot memories, tags cleared by the sweep
  logic [KB-1:0]   tag_mem [TABLE_SIZE];
  logic [KB-1:0]   key_mem [TABLE_SIZE];
  logic [VB-1:0]   val_mem [TABLE_SIZE];

  cmd_t            cmd_r;
  logic [KB-1:0]   key_r, hash_r;
  logic [VB-1:0]   val_r;
  logic [2*KB:0]   prod_r;
  logic [KB-1:0]   qp_r;
  logic [1:0]      hstep_r;
  logic [IdxW-1:0] idx_r, tomb_r, sweep_r;
  logic [CntW-1:0] n_r;
  logic            has_tomb_r;
  logic [KB-1:0]   rd_tag_r, rd_key_r;
  logic [VB-1:0]   rd_val_r;
  logic [IdxW-1:0] rd_idx_r;
  logic [CntW-1:0] live_r, used_r;
  logic            hit_r, full_r;
  logic [VB-1:0]   old_r;

  logic [KB-1:0]   key_in, hash_in;
  logic [KB-1:0]   quot, rem_home;
  logic [IdxW-1:0] free_idx;

  assign key_in   = in_key[KB-1:0];
  assign hash_in  = (key_in <= KB'(1)) ? KB'(2) : key_in;
  assign quot     = KB'(prod_r >> RecipSh);
  assign rem_home = hash_r - qp_r;
  assign free_idx = has_tomb_r ? tomb_r : rd_idx_r;

  // status back to controller
  always_comb begin
    stat.cmd        = cmd_r;
    stat.has_tomb   = has_tomb_r;
    stat.home_done  = (hstep_r == HsDone);
    stat.probe_last = (n_r == CntW'(TABLE_SIZE - 1));
    stat.sweep_last = (sweep_r == IdxW'(TABLE_SIZE - 1));
    if (rd_tag_r == '0) begin
      stat.kind = SK_EMPTY;
    end else if (rd_tag_r == KB'(1)) begin
      stat.kind = SK_TOMB;
    end else if (rd_tag_r == hash_r && rd_key_r == key_r) begin
      stat.kind = SK_MATCH;
    end else begin
      stat.kind = SK_OTHER;
    end
  end

  // command latch, home reduction and probe index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= cmd_t'(in_command);
      key_r   <= key_in;
      hash_r  <= hash_in;
      val_r   <= in_value[VB-1:0];
      hstep_r <= HsMul;
      n_r     <= '0;
    end
    if (cmd.home) begin
      hstep_r <= hstep_r + 2'd1;
      case (hstep_r)
        HsMul: begin
          prod_r <= (2*KB+1)'(hash_r) * (2*KB+1)'(RecipM);
        end
        HsQp: begin
          qp_r <= KB'((KB+PW)'(quot) * (KB+PW)'(PrimeP));
        end
        HsSub: begin
          idx_r <= IdxW'(rem_home);
        end
        default: begin
        end
      endcase
    end
    if (cmd.step) begin
      idx_r <= idx_r + n_r[IdxW-1:0] + IdxW'(1);
      n_r   <= n_r + CntW'(1);
    end
    if (cmd.note_tomb) begin
      tomb_r <= rd_idx_r;
    end
  end

  // sweep index for the reset pass and for clear
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      sweep_r <= '0;
    end else if (cmd.clr) begin
      sweep_r <= sweep_r + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_tomb_r <= 1'b0;
    end else if (cmd.load) begin
      has_tomb_r <= 1'b0;
    end else if (cmd.note_tomb) begin
      has_tomb_r <= 1'b1;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_tag_r <= tag_mem[idx_r];
      rd_key_r <= key_mem[idx_r];
      rd_val_r <= val_mem[idx_r];
      rd_idx_r <= idx_r;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      tag_mem[sweep_r] <= '0;
    end else if (cmd.wr_new) begin
      tag_mem[free_idx] <= hash_r;
      key_mem[free_idx] <= key_r;
      val_mem[free_idx] <= val_r;
    end else if (cmd.wr_upd) begin
      val_mem[rd_idx_r] <= val_r;
    end else if (cmd.wr_rm) begin
      tag_mem[rd_idx_r] <= KB'(1);
    end
  end

  // counts
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      live_r <= '0;
      used_r <= '0;
    end else if (cmd.wr_new) begin
      live_r <= live_r + CntW'(1);
      if (!has_tomb_r && rd_tag_r == '0) begin
        used_r <= used_r + CntW'(1);
      end
    end else if (cmd.wr_rm && live_r != '0) begin
      live_r <= live_r - CntW'(1);
    end
  end

  // per-command outcome
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      hit_r  <= 1'b0;
      full_r <= 1'b0;
      old_r  <= '0;
    end else begin
      if (cmd.hit) begin
        hit_r <= 1'b1;
        old_r <= rd_val_r;
      end
      if (cmd.full) begin
        full_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_busy <= 1'b0;
    end else if (cmd.emit) begin
      res_busy <= 1'b1;
    end else if (res_take) begin
      res_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_found     <= hit_r;
      res_old_value <= FieldW'(old_r);
      res_status    <= full_r;
      res_live      <= LiveW'(live_r);
    end
  end

  a_used_ge_live: assert property (@(posedge clk) disable iff (!rst_n)
    used_r >= live_r)
    else $error("live count above used count");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !res_busy || res_take)
    else $error("result register overwritten");
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.full |-> !cmd.wr_new && !has_tomb_r)
    else $error("full flagged while a free slot was known");

endmodule
`default_nettype wire

FILE: src/open_addressing_hash_table.sv
// Key/value map with open addressing and triangular probing over TABLE_SIZE
// slots. One command is taken at a time: lookup, insert/update, remove or
// clear. The key is its own hash (0 and 1 become 2); the home slot is the
// hash modulo HOME_PRIME, found by a reciprocal multiply, a multiply-back and
// a subtract. Each probe goes through the single registered port of the slot
// memory; a clear sweeps every slot, one per cycle. After reset a clearing
// pass empties every slot tag before the first command is taken. A result
// waits in an output register; the next command is accepted meanwhile and
// holds in its last cycle until that register is free.
`default_nettype none
module open_addressing_hash_table import oaht_pkg::*; #(
  parameter int TABLE_SIZE = TableSizeDef,
  parameter int HOME_PRIME = HomePrimeDef,
  parameter int KEY_BITS   = KeyBitsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input wire logic clk,
  input wire logic rst_n,
  oaht_in_if.sink    in_if,
  oaht_out_if.source out_if
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     res_busy;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .res_busy (res_busy),
    .res_take (out_if.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  oaht_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .HOME_PRIME (HOME_PRIME),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_if.command),
    .in_key        (in_if.key),
    .in_value      (in_if.value),
    .cmd           (cmd),
    .stat          (stat),
    .res_busy      (res_busy),
    .res_take      (out_if.ready),
    .res_found     (out_if.found),
    .res_old_value (out_if.old_value),
    .res_status    (out_if.status),
    .res_live      (out_if.live_entries)
  );

  assign out_if.valid = res_busy;

endmodule
`default_nettype wire
